// ===== rtl/double_ended_queue_unit_macros.svh =====
// assertion macros of the deque rtl, used by deq_ctrl
// the asserting module must have clk and arst_n in scope
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// property holds at every clock edge outside reset
`define DEQ_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define DEQ_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/deq_pkg.sv =====
// shared types and constants of the double-ended queue unit
// no dependencies
package deq_pkg;

	// default sizes
	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// command codes
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_BACK   = 3'd3;
	localparam logic [2:0] CMD_STATUS     = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_POP_EMPTY = 2'd1;
	localparam logic [1:0] ST_PUSH_FULL = 2'd2;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_LOAD = 3'b100
	} state_t;

	// result hand-off from the sequencer to the output register
	typedef struct packed {
		logic       load;
		logic [1:0] status;
	} res_ctl_t;

endpackage

// ===== rtl/deq_mem.sv =====
// ring word store of the deque: one write port, two registered read ports
// depends on nothing but its parameters
module deq_mem #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32,
	localparam int IDXW      = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [IDXW-1:0]       wr_addr,
	input  logic [DATA_WIDTH-1:0] wr_data,
	input  logic                  rd_en,
	input  logic [IDXW-1:0]       rd_addr_a,
	input  logic [IDXW-1:0]       rd_addr_b,
	output logic [DATA_WIDTH-1:0] rd_data_a,
	output logic [DATA_WIDTH-1:0] rd_data_b
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// two read ports with registered data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

// ===== rtl/deq_ctrl.sv =====
// deque sequencer: ring pointers, command decode, store access ordering
// depends on deq_pkg and the assertion macro header
`include "double_ended_queue_unit_macros.svh"

module deq_ctrl #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
	localparam int IDXW      = $clog2(DEPTH),
	localparam int CNTW      = $clog2(DEPTH + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	output logic                    cmd_stall,
	input  logic [2:0]              cmd,
	input  logic [DATA_WIDTH-1:0]   value,
	input  logic                    out_free,
	output logic                    wr_en,
	output logic [IDXW-1:0]         wr_addr,
	output logic [DATA_WIDTH-1:0]   wr_data,
	output logic                    rd_en,
	output logic [IDXW-1:0]         rd_front_addr,
	output logic [IDXW-1:0]         rd_back_addr,
	output deq_pkg::res_ctl_t       res_ctl,
	output logic [CNTW-1:0]         occupancy,
	output logic                    ends_valid
);

	localparam int SUMW = CNTW + 1;

	deq_pkg::state_t state_q;
	logic [IDXW-1:0] front_q, front_d, front_dec, front_inc, back_free;
	logic [CNTW-1:0] count_q, count_d;
	logic [1:0]      status_q, status_d;
	logic            accept, full, empty, push_wr;

	function automatic logic [IDXW-1:0] ring_wrap(input logic [SUMW-1:0] pos);
		return (pos >= SUMW'(DEPTH)) ? IDXW'(pos - SUMW'(DEPTH)) : IDXW'(pos);
	endfunction

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != deq_pkg::S_IDLE);
	assign full      = (count_q == CNTW'(DEPTH));
	assign empty     = (count_q == '0);

	// neighbor positions of the front pointer and the free slot behind the back
	assign front_dec = (front_q == '0) ? IDXW'(DEPTH - 1) : front_q - IDXW'(1);
	assign front_inc = (front_q == IDXW'(DEPTH - 1)) ? '0 : front_q + IDXW'(1);
	assign back_free = ring_wrap(SUMW'(front_q) + SUMW'(count_q));

	// command decode
	always_comb begin
		front_d  = front_q;
		count_d  = count_q;
		status_d = deq_pkg::ST_OK;
		push_wr  = 1'b0;
		wr_addr  = back_free;
		unique case (cmd)
			deq_pkg::CMD_PUSH_FRONT: begin
				if (full) begin
					status_d = deq_pkg::ST_PUSH_FULL;
				end else begin
					front_d = front_dec;
					wr_addr = front_dec;
					push_wr = 1'b1;
					count_d = count_q + CNTW'(1);
				end
			end
			deq_pkg::CMD_PUSH_BACK: begin
				if (full) begin
					status_d = deq_pkg::ST_PUSH_FULL;
				end else begin
					push_wr = 1'b1;
					count_d = count_q + CNTW'(1);
				end
			end
			deq_pkg::CMD_POP_FRONT: begin
				if (empty) begin
					status_d = deq_pkg::ST_POP_EMPTY;
				end else begin
					front_d = front_inc;
					count_d = count_q - CNTW'(1);
				end
			end
			deq_pkg::CMD_POP_BACK: begin
				if (empty) begin
					status_d = deq_pkg::ST_POP_EMPTY;
				end else begin
					count_d = count_q - CNTW'(1);
				end
			end
			deq_pkg::CMD_STATUS: begin
			end
			default: begin
			end
		endcase
	end

	assign wr_en   = accept && push_wr;
	assign wr_data = value;

	// pointer and count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			count_q  <= '0;
			status_q <= deq_pkg::ST_OK;
		end else if (accept) begin
			front_q  <= front_d;
			count_q  <= count_d;
			status_q <= status_d;
		end
	end

	// sequencer: write on transfer, read both ends, then hand over the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= deq_pkg::S_IDLE;
		end else begin
			unique case (state_q)
				deq_pkg::S_IDLE: begin
					if (accept) begin
						state_q <= deq_pkg::S_READ;
					end
				end
				deq_pkg::S_READ: begin
					state_q <= deq_pkg::S_LOAD;
				end
				deq_pkg::S_LOAD: begin
					if (out_free) begin
						state_q <= deq_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= deq_pkg::S_IDLE;
				end
			endcase
		end
	end

	// end reads use the updated pointers, in the cycle after the write
	assign rd_en         = (state_q == deq_pkg::S_READ) && !empty;
	assign rd_front_addr = front_q;
	assign rd_back_addr  = ring_wrap(SUMW'(front_q) + SUMW'(count_q) - SUMW'(1));

	assign res_ctl.load   = (state_q == deq_pkg::S_LOAD) && out_free;
	assign res_ctl.status = status_q;
	assign occupancy      = count_q;
	assign ends_valid     = !empty;

	// checks
	`DEQ_ASSERT_ALWAYS(a_count_bound, count_q <= CNTW'(DEPTH), "word count above depth")
	`DEQ_ASSERT_IMPLY(a_count_hold, !$past(accept), $stable(count_q),
		"count moved without transfer")
	`DEQ_ASSERT_NEXT(a_read_then_load, state_q == deq_pkg::S_READ,
		state_q == deq_pkg::S_LOAD, "end read not followed by load")

endmodule

// ===== rtl/double_ended_queue_unit.sv =====
// Double-ended queue of signed words in a ring store.
// Command channel: cmd_valid / cmd_stall with cmd (0 push front, 1 push back,
// 2 pop front, 3 pop back, 4 to 7 status read) and value, the word to push.
// Result channel: res_valid / res_stall with status (0 done, 1 pop on empty
// ignored, 2 push on full rejected), occupancy, ends_valid, front_word and
// back_word, all as they stand after the command. Empty ends read as zero.
// Exactly one result per command, in command order.
// Timing: a command is written to the store at its transfer edge, both end
// words are read from the store in the next cycle (S_READ) and land in the
// result register from S_LOAD once that register is free. A command steps
// through S_READ and S_LOAD because the store's read is registered after the
// write. cmd_stall is high while a command is in flight.
// A result held under res_stall does not block the next command: it is
// accepted and worked on, and waits for the result register to free up.
// Reset clears the pointers and the count (empty queue) and drops res_valid;
// store contents are not cleared and need no clearing pass.
// depends on deq_pkg, deq_mem and deq_ctrl
module double_ended_queue_unit #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
	localparam int IDXW      = $clog2(DEPTH),
	localparam int CNTW      = $clog2(DEPTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	input  logic [2:0]                   cmd,
	input  logic signed [DATA_WIDTH-1:0] value,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic [1:0]                   status,
	output logic [CNTW-1:0]              occupancy,
	output logic                         ends_valid,
	output logic signed [DATA_WIDTH-1:0] front_word,
	output logic signed [DATA_WIDTH-1:0] back_word
);

	logic                  wr_en, rd_en, out_free, valid_q, ends_c;
	logic [IDXW-1:0]       wr_addr, rd_front_addr, rd_back_addr;
	logic [DATA_WIDTH-1:0] wr_data, rd_front_data, rd_back_data;
	logic [CNTW-1:0]       occ_c;
	deq_pkg::res_ctl_t     res_ctl;

	deq_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.cmd           (cmd),
		.value         (value),
		.out_free      (out_free),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_en         (rd_en),
		.rd_front_addr (rd_front_addr),
		.rd_back_addr  (rd_back_addr),
		.res_ctl       (res_ctl),
		.occupancy     (occ_c),
		.ends_valid    (ends_c)
	);

	deq_mem #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_mem (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr_a (rd_front_addr),
		.rd_addr_b (rd_back_addr),
		.rd_data_a (rd_front_data),
		.rd_data_b (rd_back_data)
	);

	// result register is free when empty or its result transfers this cycle
	assign out_free = !valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ctl.load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	// result payload, end words forced to zero on an empty queue
	always_ff @(posedge clk) begin
		if (res_ctl.load) begin
			status     <= res_ctl.status;
			occupancy  <= occ_c;
			ends_valid <= ends_c;
			front_word <= ends_c ? rd_front_data : '0;
			back_word  <= ends_c ? rd_back_data : '0;
		end
	end

	assign res_valid = valid_q;

endmodule
